// File: sv/indexed_list_store_top_macros.svh
// assertion macros for the indexed list store checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef INDEXED_LIST_STORE_TOP_MACROS_SVH
`define INDEXED_LIST_STORE_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ILS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ils_pkg.sv
// shared types and codes for the indexed list store
// no dependencies
`timescale 1ns / 1ps

package ils_pkg;

    // fixed field widths
    localparam int KIND_W    = 3;
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 11;
    localparam int STATUS_W  = 2;

    localparam int DEFAULT_CAPACITY = 1024;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BACK      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FRONT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET_AT    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_GET_AT    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_INSERT_AT = 3'd6;
    localparam logic [KIND_W-1:0] KIND_REMOVE_AT = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// File: sv/ils_ram.sv
// single-port-write, single-port-read word memory with registered read data
// depends on ils_pkg for default widths
`timescale 1ns / 1ps

module ils_ram #(
    parameter int DEPTH  = ils_pkg::DEFAULT_CAPACITY,
    parameter int DATA_W = ils_pkg::DATA_W,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data valid the cycle after re
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/indexed_list_store_top.sv
// indexed list store: ordered list of signed words in one memory, shifted word by word
// push, pop, set, append and rejected ops answer straight from the idle state; back, front, get
// wait on a memory read; insert and remove move entries one at a time, and insert then writes the new word
// one item at a time: input closed until the result transfer
// reset (aresetn low, synchronous) empties the list; memory contents are not cleared
// depends on ils_pkg and ils_ram
`timescale 1ns / 1ps

module indexed_list_store_top #(
    parameter int CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ils_pkg::KIND_W-1:0]          s_kind,
    input  logic [ils_pkg::IDX_W-1:0]           s_index,
    input  logic signed [ils_pkg::DATA_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ils_pkg::DATA_W-1:0]   m_read_value,
    output logic [ils_pkg::CNT_OUT_W-1:0]       m_count,
    output logic                                m_empty_res,
    output logic [ils_pkg::STATUS_W-1:0]        m_status
);

    import ils_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int OUT_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_RDWAIT = 3'd1;
    localparam logic [ST_W-1:0] ST_SHIFT  = 3'd2;
    localparam logic [ST_W-1:0] ST_PLACE  = 3'd3;
    localparam logic [ST_W-1:0] ST_RESP   = 3'd4;

    logic [ST_W-1:0]     state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    rp_reg, rp_next;
    logic [CNT_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    tgt_reg, tgt_next;
    logic                ins_reg, ins_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   rv_reg, rv_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    logic                is_empty;
    logic                is_full;
    logic [CNT_W-1:0]    fill_dec;
    logic [CNT_W-1:0]    fill_inc;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    fill_ext;
    logic                idx_ge;
    logic [CNT_W-1:0]    idx_clamp;
    logic [CNT_W-1:0]    ins_tgt;
    logic [CNT_W-1:0]    rm_first;
    logic [CNT_W-1:0]    step;
    logic [CNT_W-1:0]    step_sum;
    logic [OUT_W-1:0]    cnt_wide;

    ils_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (DATA_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // list status and index clamping
    assign is_empty  = (fill_reg == '0);
    assign is_full   = (fill_reg == CAP_CNT);
    assign fill_dec  = fill_reg - CNT_W'(1);
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign idx_ext   = CMP_W'(s_index);
    assign fill_ext  = CMP_W'(fill_reg);
    assign idx_ge    = (idx_ext >= fill_ext);
    assign idx_clamp = idx_ge ? fill_dec : idx_ext[CNT_W-1:0];
    assign ins_tgt   = idx_ge ? fill_reg : idx_ext[CNT_W-1:0];
    assign rm_first  = idx_clamp + CNT_W'(1);

    // shared pointer stepper: down for insert, up for remove
    assign step     = ins_reg ? {CNT_W{1'b1}} : CNT_W'(1);
    assign step_sum = rp_reg + step;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        tgt_next    = tgt_reg;
        ins_next    = ins_reg;
        val_next    = val_reg;
        rv_next     = rv_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = s_value;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next = STATUS_OK;
                    rv_next     = '0;
                    val_next    = s_value;
                    state_next  = ST_RESP;
                    unique case (s_kind)
                        KIND_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_reg[ADDR_W-1:0];
                                fill_next = fill_inc;
                            end
                        end
                        KIND_POP_BACK: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                fill_next = fill_dec;
                            end
                        end
                        KIND_BACK: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = fill_dec[ADDR_W-1:0];
                                state_next = ST_RDWAIT;
                            end
                        end
                        KIND_FRONT: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = ST_RDWAIT;
                            end
                        end
                        KIND_SET_AT: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_clamp[ADDR_W-1:0];
                            end
                        end
                        KIND_GET_AT: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_clamp[ADDR_W-1:0];
                                state_next = ST_RDWAIT;
                            end
                        end
                        KIND_INSERT_AT: begin
                            if (is_full) begin
                                status_next = STATUS_FULL;
                            end else if (ins_tgt == fill_reg) begin
                                // append, nothing to move
                                mem_we    = 1'b1;
                                mem_waddr = fill_reg[ADDR_W-1:0];
                                fill_next = fill_inc;
                            end else begin
                                // start moving entries up from the tail
                                mem_re     = 1'b1;
                                mem_raddr  = fill_dec[ADDR_W-1:0];
                                rp_next    = fill_dec;
                                wp_next    = fill_reg;
                                tgt_next   = ins_tgt;
                                ins_next   = 1'b1;
                                state_next = ST_SHIFT;
                            end
                        end
                        KIND_REMOVE_AT: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end else if (idx_clamp == fill_dec) begin
                                // last entry, just drop it
                                fill_next = fill_dec;
                            end else begin
                                // start moving entries down above the hole
                                mem_re     = 1'b1;
                                mem_raddr  = rm_first[ADDR_W-1:0];
                                rp_next    = rm_first;
                                wp_next    = idx_clamp;
                                ins_next   = 1'b0;
                                state_next = ST_SHIFT;
                            end
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                rv_next    = mem_rdata;
                state_next = ST_RESP;
            end
            ST_SHIFT: begin
                // write the word read last cycle, read the next one
                mem_we    = 1'b1;
                mem_waddr = wp_reg[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                if (ins_reg && (rp_reg == tgt_reg)) begin
                    state_next = ST_PLACE;
                end else if (!ins_reg && (step_sum == fill_reg)) begin
                    fill_next  = fill_dec;
                    state_next = ST_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = step_sum[ADDR_W-1:0];
                    rp_next   = step_sum;
                    wp_next   = rp_reg;
                end
            end
            ST_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg[ADDR_W-1:0];
                mem_wdata  = val_reg;
                fill_next  = fill_inc;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rp_reg     <= rp_next;
        wp_reg     <= wp_next;
        tgt_reg    <= tgt_next;
        ins_reg    <= ins_next;
        val_reg    <= val_next;
        rv_reg     <= rv_next;
        status_reg <= status_next;
    end

    // ports
    assign cnt_wide     = OUT_W'(fill_reg);
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_RESP);
    assign m_read_value = rv_reg;
    assign m_count      = cnt_wide[CNT_OUT_W-1:0];
    assign m_empty_res  = is_empty;
    assign m_status     = status_reg;

endmodule

// File: sv/ils_checker.sv
// port-level checks for the indexed list store, bound to the top level
// depends on ils_pkg and indexed_list_store_top_macros.svh
`timescale 1ns / 1ps
`include "indexed_list_store_top_macros.svh"

module ils_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [ils_pkg::DATA_W-1:0]   m_read_value,
    input logic [ils_pkg::CNT_OUT_W-1:0]       m_count,
    input logic                                m_empty_res,
    input logic [ils_pkg::STATUS_W-1:0]        m_status
);

    import ils_pkg::*;

    // one item in flight: ready drops after an input transfer
    `ILS_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready, "ready after input transfer")

    // input side closed while a result waits
    `ILS_ASSERT_SAME(a_one_at_a_time, m_valid, !s_ready, "ready while result pending")

    // empty flag agrees with the reported count
    `ILS_ASSERT_SAME(a_empty_count, m_valid && m_empty_res, m_count == '0, "empty with count")

    // rejected operations read nothing
    `ILS_ASSERT_SAME(a_no_read_on_reject, m_valid && (m_status != STATUS_OK), m_read_value == '0, "read value on rejected op")

    // stalled result holds
    `ILS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_read_value) && $stable(m_count) && $stable(m_status), "result changed while stalled")

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (.*);

// File: bench/tb.sv
// self-checking bench for indexed_list_store_top: random and directed list operations
// a shadow list in a small class predicts every result; depends on ils_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
    import ils_pkg::*;

    localparam int LIST_CAP = DEFAULT_CAPACITY;
    localparam int DRAIN_CYCLES = LIST_CAP + 100;

    typedef struct packed {
        logic [DATA_W-1:0]    read_value;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty_res;
        logic [STATUS_W-1:0]  status;
    } list_result_t;

    // shadow copy of the list and the results still owed by the block
    class list_shadow;
        int capacity;
        logic [DATA_W-1:0] held_words[$];
        list_result_t awaited[$];
        int failures;

        function new(int cap);
            capacity = cap;
            failures = 0;
        endfunction

        // apply one request to the shadow list and return the result it must give
        function list_result_t apply_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] index,
                                             logic [DATA_W-1:0] value);
            list_result_t r;
            int n;
            int pos;
            n = held_words.size();
            r = '0;
            r.status = STATUS_OK;
            pos = (int'(index) >= n) ? n - 1 : int'(index);
            case (kind)
                KIND_PUSH_BACK: begin
                    if (n >= capacity) r.status = STATUS_FULL;
                    else held_words.push_back(value);
                end
                KIND_POP_BACK: begin
                    if (n == 0) r.status = STATUS_EMPTY;
                    else void'(held_words.pop_back());
                end
                KIND_BACK: begin
                    if (n == 0) r.status = STATUS_EMPTY;
                    else r.read_value = held_words[n-1];
                end
                KIND_FRONT: begin
                    if (n == 0) r.status = STATUS_EMPTY;
                    else r.read_value = held_words[0];
                end
                KIND_SET_AT: begin
                    if (n == 0) r.status = STATUS_EMPTY;
                    else held_words[pos] = value;
                end
                KIND_GET_AT: begin
                    if (n == 0) r.status = STATUS_EMPTY;
                    else r.read_value = held_words[pos];
                end
                KIND_INSERT_AT: begin
                    // an index past the end appends
                    if (n >= capacity) r.status = STATUS_FULL;
                    else held_words.insert((int'(index) > n) ? n : int'(index), value);
                end
                default: begin
                    if (n == 0) r.status = STATUS_EMPTY;
                    else held_words.delete(pos);
                end
            endcase
            r.count = CNT_OUT_W'(held_words.size());
            r.empty_res = (held_words.size() == 0);
            return r;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] index,
                                   logic [DATA_W-1:0] value);
            awaited.push_back(apply_request(kind, index, value));
        endfunction

        function void check_response(logic [DATA_W-1:0] rv, logic [CNT_OUT_W-1:0] cnt,
                                     logic emp, logic [STATUS_W-1:0] st);
            list_result_t e;
            if (awaited.size() == 0) begin
                $error("result transfer with nothing outstanding: read_value %0d count %0d",
                       $signed(rv), cnt);
                failures++;
                return;
            end
            e = awaited.pop_front();
            if (rv !== e.read_value) begin
                $error("read_value mismatch: expected %0d, actual %0d",
                       $signed(e.read_value), $signed(rv));
                failures++;
            end
            if (cnt !== e.count) begin
                $error("count mismatch: expected %0d, actual %0d", e.count, cnt);
                failures++;
            end
            if (emp !== e.empty_res) begin
                $error("empty_res mismatch: expected %0b, actual %0b", e.empty_res, emp);
                failures++;
            end
            if (st !== e.status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, st);
                failures++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [KIND_W-1:0] s_kind = '0;
    logic [IDX_W-1:0] s_index = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_read_value;
    logic [CNT_OUT_W-1:0] m_count;
    logic m_empty_res;
    logic [STATUS_W-1:0] m_status;

    int send_idle_pct = 26;
    int recv_idle_pct = 48;
    list_shadow shadow = new(LIST_CAP);

    indexed_list_store_top #(
        .CAPACITY(LIST_CAP)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_index     (s_index),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_value(m_read_value),
        .m_count     (m_count),
        .m_empty_res (m_empty_res),
        .m_status    (m_status)
    );

    always #5 aclk = ~aclk;

    // result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            shadow.check_response(m_read_value, m_count, m_empty_res, m_status);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // present one request and hold it until the transfer
    task automatic send_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] index,
                             logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_index <= index;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(kind, index, value);
    endtask

    // keep the list short most of the time so shifts stay cheap
    function automatic logic [KIND_W-1:0] pick_kind(int n);
        if (n < 3 && $urandom_range(1) == 1)
            return ($urandom_range(1) == 1) ? KIND_PUSH_BACK : KIND_INSERT_AT;
        if (n > 40 && $urandom_range(1) == 1)
            return ($urandom_range(1) == 1) ? KIND_POP_BACK : KIND_REMOVE_AT;
        return KIND_W'($urandom_range(7));
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int n);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return IDX_W'($urandom_range(1023));
            default: return IDX_W'($urandom_range(n));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_run(int items);
        int n;
        repeat (items) begin
            n = shadow.held_words.size();
            send_item(pick_kind(n), pick_index(n), pick_value());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list: every operation that needs an entry is refused
        send_item(KIND_POP_BACK, 10'd0, 32'd0);
        send_item(KIND_BACK, 10'd0, 32'd0);
        send_item(KIND_FRONT, 10'd0, 32'd0);
        send_item(KIND_SET_AT, 10'd0, 32'h0bad_0bad);
        send_item(KIND_GET_AT, 10'h3ff, 32'd0);
        send_item(KIND_REMOVE_AT, 10'd0, 32'd0);
        // insert past the end appends, then pushes of extreme words
        send_item(KIND_INSERT_AT, 10'h3ff, 32'h7fff_ffff);
        send_item(KIND_PUSH_BACK, 10'h3ff, 32'h8000_0000);
        send_item(KIND_PUSH_BACK, 10'd0, 32'hffff_ffff);
        send_item(KIND_PUSH_BACK, 10'd0, 32'd0);
        send_item(KIND_FRONT, 10'd0, 32'd0);
        send_item(KIND_BACK, 10'd0, 32'd0);
        send_item(KIND_GET_AT, 10'd1, 32'd0);
        // indexes at or past the count clamp to the last entry
        send_item(KIND_GET_AT, 10'h3ff, 32'd0);
        send_item(KIND_GET_AT, 10'd4, 32'd0);
        send_item(KIND_SET_AT, 10'h3ff, 32'h5555_5555);
        send_item(KIND_INSERT_AT, 10'd0, 32'h1234_5678);
        send_item(KIND_INSERT_AT, 10'd2, 32'haaaa_aaaa);
        send_item(KIND_INSERT_AT, 10'd6, 32'h0f0f_0f0f);
        send_item(KIND_REMOVE_AT, 10'h3ff, 32'd0);
        send_item(KIND_REMOVE_AT, 10'd0, 32'd0);
        send_item(KIND_REMOVE_AT, 10'd2, 32'd0);
        send_item(KIND_SET_AT, 10'd0, 32'hdead_beef);
        send_item(KIND_GET_AT, 10'd0, 32'd0);
        send_item(KIND_POP_BACK, 10'd0, 32'd0);

        // random traffic under three idle patterns
        random_run(180);
        send_idle_pct = 48;
        recv_idle_pct = 26;
        random_run(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_run(180);

        // closing mix of shifts at far indexes and reads around them
        send_item(KIND_PUSH_BACK, 10'd0, 32'h1111_1111);
        send_item(KIND_INSERT_AT, 10'd0, 32'h2222_2222);
        send_item(KIND_GET_AT, 10'h3ff, 32'd0);
        send_item(KIND_SET_AT, 10'h3ff, 32'h3333_3333);
        send_item(KIND_BACK, 10'd0, 32'd0);
        send_item(KIND_REMOVE_AT, 10'd0, 32'd0);
        send_item(KIND_FRONT, 10'd0, 32'd0);
        send_item(KIND_INSERT_AT, 10'd0, 32'h4444_4444);
        send_item(KIND_REMOVE_AT, 10'd500, 32'd0);
        send_item(KIND_INSERT_AT, 10'h3ff, 32'h6666_6666);
        send_item(KIND_GET_AT, 10'd500, 32'd0);
        send_item(KIND_POP_BACK, 10'd0, 32'd0);
        send_item(KIND_INSERT_AT, 10'd1, 32'h7777_7777);
        send_item(KIND_FRONT, 10'd0, 32'd0);
        send_item(KIND_PUSH_BACK, 10'd0, 32'h8888_8888);
        s_valid <= 1'b0;

        // let outstanding results arrive, then watch for strays
        while (shadow.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (shadow.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
